// File: hdl/fpm_pkg.sv
// Shared constants, codes and types of the pair matcher.
`default_nettype none

package fpm_pkg;

  // Identifier and queue geometry.
  localparam int ID_W     = 10;
  localparam int ID_COUNT = 1024;
  localparam int ID_AW    = $clog2(ID_COUNT);
  localparam int Q_DEPTH  = 64;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = Q_AW + 1;

  // Command codes.
  localparam logic [1:0] CMD_ADD_CONS = 2'd0;
  localparam logic [1:0] CMD_ADD_PROV = 2'd1;
  localparam logic [1:0] CMD_MATCH    = 2'd2;
  localparam logic [1:0] CMD_CANCEL   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_MATCHED  = 2'd1;
  localparam logic [1:0] STAT_NO_MATCH = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef logic [ID_W-1:0] id_t;

  // Requests from the sequencer to one queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } q_ctrl_t;

  // Occupancy flags reported by one queue.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: hdl/fpm_queue.sv
// Circular ID queue held in a synchronous memory with head and count registers.
`default_nettype none

module fpm_queue
  import fpm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_ctrl_t ctrl,
  input  wire id_t     wr_data,
  output id_t          rd_data,
  output q_stat_t      stat
);

  id_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]  head;
  logic [Q_CW-1:0]  count;
  logic [Q_AW-1:0]  tail;
  logic             do_push;
  logic             do_pop;

  // The tail wraps naturally because the depth is a power of two.
  assign tail       = head + count[Q_AW-1:0];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == Q_CW'(Q_DEPTH));
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;

  // Head pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (do_push) begin
      count <= count + 1'b1;
    end else if (do_pop) begin
      head  <= head + 1'b1;
      count <= count - 1'b1;
    end
  end

  // Entry storage: write at the tail, registered read at the head.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= wr_data;
    end
    if (ctrl.rd) begin
      rd_data <= mem[head];
    end
  end

endmodule

`default_nettype wire

// File: hdl/fifo_pair_matcher_with_cancel.sv
// Add consumer, add provider and cancel load the result register on acceptance.
// A match walks the consumer head, skipping the cancelled consumers found there;
// each head examined costs a queue read, a bitmap read and a test of the active bit.
// A match on an empty consumer queue reports no match. One transaction is in work at a time.
// After reset the active bitmap is cleared in a pass over all IDs with cmd_stall high;
// queues start empty and the result register starts invalid.
`default_nettype none

module fifo_pair_matcher_with_cancel
  import fpm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  output logic            cmd_stall,
  input  wire logic [1:0] command,
  input  wire id_t        id,
  output logic            res_valid,
  input  wire logic       res_stall,
  output logic [1:0]      status,
  output id_t             provider_id,
  output id_t             consumer_id
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FRONT = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [ID_AW-1:0] clr_idx;
  logic             ready;
  logic             accept;

  q_ctrl_t          cq_ctrl;
  q_ctrl_t          pq_ctrl;
  q_stat_t          cq_stat;
  q_stat_t          pq_stat;
  id_t              cq_rd;
  id_t              pq_rd;

  logic             active_mem [ID_COUNT];
  logic             bm_we;
  logic [ID_AW-1:0] bm_waddr;
  logic             bm_wdata;
  logic             bm_re;
  logic [ID_AW-1:0] bm_raddr;
  logic             bm_rdata;

  logic             res_load;
  logic [1:0]       status_next;
  id_t              prov_next;
  id_t              cons_next;

  // Consumer and provider queues.
  fpm_queue u_cons_q (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cq_ctrl),
    .wr_data (id),
    .rd_data (cq_rd),
    .stat    (cq_stat)
  );

  fpm_queue u_prov_q (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (pq_ctrl),
    .wr_data (id),
    .rd_data (pq_rd),
    .stat    (pq_stat)
  );

  // A new transaction is taken when idle and the result register is free or draining.
  assign ready     = (state == S_IDLE) && (!res_valid || !res_stall);
  assign accept    = cmd_valid && ready;
  assign cmd_stall = !ready;

  // Active bitmap memory with a registered read port.
  always_ff @(posedge clk) begin
    if (bm_we) begin
      active_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata <= active_mem[bm_raddr];
    end
  end

  // Sequencer: clears the bitmap after reset, decodes commands and walks the consumer head on a match.
  always_comb begin
    state_next  = state;
    cq_ctrl     = '0;
    pq_ctrl     = '0;
    bm_we       = 1'b0;
    bm_waddr    = id[ID_AW-1:0];
    bm_wdata    = 1'b0;
    bm_re       = 1'b0;
    bm_raddr    = cq_rd[ID_AW-1:0];
    res_load    = 1'b0;
    status_next = STAT_ACCEPTED;
    prov_next   = '0;
    cons_next   = '0;
    case (state)
      S_CLEAR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_idx;
        if (clr_idx == ID_AW'(ID_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ADD_CONS: begin
              res_load = 1'b1;
              if (cq_stat.full) begin
                status_next = STAT_FULL;
              end else begin
                cq_ctrl.push = 1'b1;
                bm_we        = 1'b1;
                bm_wdata     = 1'b1;
              end
            end
            CMD_ADD_PROV: begin
              res_load = 1'b1;
              if (pq_stat.full) begin
                status_next = STAT_FULL;
              end else begin
                pq_ctrl.push = 1'b1;
              end
            end
            CMD_MATCH: begin
              state_next = S_FRONT;
            end
            default: begin
              // Cancel only clears the active bit and reports acceptance.
              res_load = 1'b1;
              bm_we    = 1'b1;
            end
          endcase
        end
      end
      S_FRONT: begin
        if (cq_stat.empty) begin
          res_load    = 1'b1;
          status_next = STAT_NO_MATCH;
          state_next  = S_IDLE;
        end else begin
          cq_ctrl.rd = 1'b1;
          pq_ctrl.rd = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        bm_re      = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        if (!bm_rdata) begin
          // Cancelled consumer at the head is discarded.
          cq_ctrl.pop = 1'b1;
          state_next  = S_FRONT;
        end else if (pq_stat.empty) begin
          res_load    = 1'b1;
          status_next = STAT_NO_MATCH;
          state_next  = S_IDLE;
        end else begin
          cq_ctrl.pop = 1'b1;
          pq_ctrl.pop = 1'b1;
          bm_we       = 1'b1;
          bm_waddr    = cq_rd[ID_AW-1:0];
          res_load    = 1'b1;
          status_next = STAT_MATCHED;
          prov_next   = pq_rd;
          cons_next   = cq_rd;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and clearing-pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= status_next;
      provider_id <= prov_next;
      consumer_id <= cons_next;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_fifo_pair_matcher_with_cancel.sv
// Self-checking testbench for the consumer/provider pair matcher with lazy cancellation.
module tb_fifo_pair_matcher_with_cancel;
  import fpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RAND_ITEMS   = 600;
  localparam int IDLE_PCT     = 34;
  localparam int CMD_CALM_LO  = 1400;
  localparam int CMD_CALM_HI  = 1900;
  localparam int RES_CALM_LO  = 1500;
  localparam int RES_CALM_HI  = 2000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [1:0] cmd;
    id_t        id;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    id_t        prov;
    id_t        cons;
  } outcome_t;

  // Command mixes used by the random bursts.
  typedef enum {MIX_BALANCED, MIX_FILL_CONS, MIX_FILL_PROV, MIX_DRAIN, MIX_CANCEL} mix_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [1:0] command = CMD_ADD_CONS;
  id_t        id = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] status;
  id_t        provider_id;
  id_t        consumer_id;

  cmd_item_t  cmd_q[$];
  outcome_t   outcome_q[$];

  int cycle_count = 0;
  int err_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int matched_count = 0;
  int empty_count = 0;
  int full_count = 0;

  // Mirror of the block state kept by the predictor.
  id_t             cons_slot [Q_DEPTH];
  id_t             prov_slot [Q_DEPTH];
  logic [Q_AW-1:0] cons_head = '0;
  logic [Q_CW-1:0] cons_count = '0;
  logic [Q_AW-1:0] prov_head = '0;
  logic [Q_CW-1:0] prov_count = '0;
  logic            cons_active [ID_COUNT];

  fifo_pair_matcher_with_cancel dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .command    (command),
    .id         (id),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .provider_id(provider_id),
    .consumer_id(consumer_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ID_COUNT; i++) cons_active[i] = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Computes the outcome of one command and advances the mirrored state.
  function automatic outcome_t matcher_outcome(cmd_item_t it);
    outcome_t        res;
    logic [Q_AW-1:0] idx;
    res = '{status: STAT_ACCEPTED, prov: '0, cons: '0};
    case (it.cmd)
      CMD_ADD_CONS: begin
        if (cons_count == Q_CW'(Q_DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          idx = cons_head + cons_count[Q_AW-1:0];
          cons_slot[idx] = it.id;
          cons_count = cons_count + 1'b1;
          cons_active[it.id] = 1'b1;
        end
      end
      CMD_ADD_PROV: begin
        if (prov_count == Q_CW'(Q_DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          idx = prov_head + prov_count[Q_AW-1:0];
          prov_slot[idx] = it.id;
          prov_count = prov_count + 1'b1;
        end
      end
      CMD_MATCH: begin
        // Cancelled consumers at the head are discarded for good.
        while (cons_count != 0 && !cons_active[cons_slot[cons_head]]) begin
          cons_head = cons_head + 1'b1;
          cons_count = cons_count - 1'b1;
        end
        if (cons_count == 0 || prov_count == 0) begin
          res.status = STAT_NO_MATCH;
        end else begin
          res.status = STAT_MATCHED;
          res.prov = prov_slot[prov_head];
          res.cons = cons_slot[cons_head];
          prov_head = prov_head + 1'b1;
          prov_count = prov_count - 1'b1;
          cons_head = cons_head + 1'b1;
          cons_count = cons_count - 1'b1;
          cons_active[res.cons] = 1'b0;
        end
      end
      CMD_CANCEL: begin
        cons_active[it.id] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic idle_roll(int lo, int hi);
    if (cycle_count >= lo && cycle_count < hi) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  task automatic queue_cmd(logic [1:0] cmd, id_t ident);
    cmd_q.push_back('{cmd: cmd, id: ident});
  endtask

  task automatic report_mismatch(string what, outcome_t want);
    err_count++;
    if (err_count <= SHOW_LIMIT) begin
      $display("[%0t] %s: expected status %0d prov %0d cons %0d, got status %0d prov %0d cons %0d",
               $realtime, what, want.status, want.prov, want.cons,
               status, provider_id, consumer_id);
    end
  endtask

  // Command driver: presents the oldest pending command and holds it while stalled.
  always @(posedge clk) begin : cmd_driver
    logic take;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      take = cmd_valid && !cmd_stall;
      if (take) begin
        outcome_q.push_back(matcher_outcome(cmd_q.pop_front()));
        accepted_count++;
      end
      if (cmd_valid && !take) begin
        // Stalled transaction keeps its payload.
      end else if (cmd_q.size() != 0 && !idle_roll(CMD_CALM_LO, CMD_CALM_HI)) begin
        cmd_valid <= 1'b1;
        command <= cmd_q[0].cmd;
        id <= cmd_q[0].id;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= idle_roll(RES_CALM_LO, RES_CALM_HI);
    end
  end

  // Result monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : res_monitor
    outcome_t want;
    if (!rst && res_valid && !res_stall) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        want = outcome_q.pop_front();
        checked_count++;
        if (want.status == STAT_MATCHED) matched_count++;
        if (want.status == STAT_NO_MATCH) empty_count++;
        if (want.status == STAT_FULL) full_count++;
        if (status !== want.status || provider_id !== want.prov || consumer_id !== want.cons)
          report_mismatch("result mismatch", want);
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d commands pending and %0d results outstanding.",
             cycle_count, cmd_q.size(), outcome_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus and end of test.
  initial begin : stimulus
    mix_t mix;
    int   burst_len;
    int   burst_idx;
    int   n_rand;
    int   r;
    int   w_cons;
    int   w_prov;
    int   w_match;
    id_t  last_cons;
    cmd_item_t it;

    // Directed part: empty sides, extreme IDs, duplicates and lazy cancellation.
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_CANCEL, 10'd1023);
    queue_cmd(CMD_ADD_CONS, 10'd0);
    queue_cmd(CMD_ADD_CONS, 10'd1023);
    queue_cmd(CMD_ADD_PROV, 10'd1023);
    queue_cmd(CMD_ADD_PROV, 10'd0);
    queue_cmd(CMD_MATCH, 10'd1023);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_ADD_CONS, 10'd5);
    queue_cmd(CMD_ADD_CONS, 10'd5);
    queue_cmd(CMD_ADD_PROV, 10'd7);
    queue_cmd(CMD_ADD_PROV, 10'd8);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_ADD_CONS, 10'd9);
    queue_cmd(CMD_CANCEL, 10'd9);
    queue_cmd(CMD_ADD_CONS, 10'd10);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_ADD_CONS, 10'd12);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_CANCEL, 10'd12);
    queue_cmd(CMD_ADD_PROV, 10'd682);
    queue_cmd(CMD_MATCH, 10'd0);
    queue_cmd(CMD_ADD_CONS, 10'd341);

    // Random bursts; the first two push each queue past full.
    n_rand = 0;
    burst_idx = 0;
    last_cons = 10'd341;
    while (n_rand < RAND_ITEMS) begin
      if (burst_idx == 0) begin
        mix = MIX_FILL_CONS;
        burst_len = 90;
      end else if (burst_idx == 1) begin
        mix = MIX_FILL_PROV;
        burst_len = 90;
      end else begin
        mix = mix_t'($urandom_range(0, 4));
        burst_len = $urandom_range(20, 90);
      end
      case (mix)
        MIX_FILL_CONS: begin w_cons = 85; w_prov = 90; w_match = 95; end
        MIX_FILL_PROV: begin w_cons = 5;  w_prov = 90; w_match = 95; end
        MIX_DRAIN:     begin w_cons = 10; w_prov = 20; w_match = 90; end
        MIX_CANCEL:    begin w_cons = 25; w_prov = 30; w_match = 50; end
        default:       begin w_cons = 30; w_prov = 60; w_match = 85; end
      endcase
      for (int k = 0; k < burst_len && n_rand < RAND_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < w_cons) it.cmd = CMD_ADD_CONS;
        else if (r < w_prov) it.cmd = CMD_ADD_PROV;
        else if (r < w_match) it.cmd = CMD_MATCH;
        else it.cmd = CMD_CANCEL;
        // A small pool of IDs makes cancels and duplicates hit queued consumers.
        r = $urandom_range(0, 9);
        if (r < 4) it.id = id_t'($urandom_range(0, 15));
        else if (r < 6) it.id = last_cons;
        else it.id = id_t'($urandom_range(0, ID_COUNT - 1));
        if (it.cmd == CMD_ADD_CONS) last_cons = it.id;
        cmd_q.push_back(it);
        n_rand++;
      end
      burst_idx++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (outcome_q.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived.", outcome_q.size());
    end

    $display("Ran %0d commands in %0d cycles and checked %0d results.",
             accepted_count, cycle_count, checked_count);
    $display("Outcomes: %0d pairs matched, %0d matches with an empty side, %0d adds dropped.",
             matched_count, empty_count, full_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/fpm_pkg.sv
hdl/fpm_queue.sv
hdl/fifo_pair_matcher_with_cancel.sv
sim/tb_fifo_pair_matcher_with_cancel.sv
